/* rtl/assert_macros.svh */
// Assertion macros used by the ray/sphere intersection top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/rsi_pkg.sv */
// Types, widths and register codes of the ray/sphere intersection block.
package rsi_pkg;

    localparam int COORD_BITS    = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int UNIT_BITS     = 30;

    localparam int AM_W   = COORD_BITS + 1;        // |center - origin|
    localparam int NM_W   = COORD_BITS - 1;        // normalized direction magnitude
    localparam int LZ_W   = $clog2(COORD_BITS + 1);
    localparam int DSQ_W  = 2 * NM_W + 2;          // sum of squared directions
    localparam int LEN_W  = DSQ_W / 2;
    localparam int NUM_W  = NM_W + UNIT_BITS;      // divider numerator
    localparam int UM_W   = UNIT_BITS + 1;         // unit component magnitude
    localparam int PROD_W = AM_W + UM_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int SQ_W   = 2 * AM_W;
    localparam int ASQ_W  = SQ_W + 2;
    localparam int TM_W   = AM_W + 1;
    localparam int R_W    = COORD_BITS - 1;
    localparam int R2_W   = 2 * R_W;
    localparam int KM_W   = TM_W + 1;
    localparam int KP_W   = KM_W + UM_W;
    localparam int DL_W   = KP_W + 1 - UNIT_BITS;
    localparam int P_W    = DL_W + 2;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_RADIUS
    } cfg_reg_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] origin_x;
        logic signed [COORD_BITS-1:0] origin_y;
        logic signed [COORD_BITS-1:0] origin_z;
        logic signed [COORD_BITS-1:0] dir_x;
        logic signed [COORD_BITS-1:0] dir_y;
        logic signed [COORD_BITS-1:0] dir_z;
    } ray_t;

    typedef struct packed {
        logic                         hit;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
    } hit_t;

    typedef struct packed {
        logic [2:0][AM_W-1:0]       am;
        logic [2:0]                 an;
        logic [2:0]                 dn;
        logic [2:0][NM_W-1:0]       dmn;
        logic [2:0][COORD_BITS-1:0] o;
        logic                       zero;
    } front_side_t;

    typedef struct packed {
        logic [2:0][AM_W-1:0]       am;
        logic [2:0]                 an;
        logic [2:0]                 dn;
        logic [2:0][COORD_BITS-1:0] o;
        logic                       zero;
    } dot_side_t;

    typedef struct packed {
        logic [2:0][UM_W-1:0]       um;
        logic [2:0]                 dn;
        logic [2:0][COORD_BITS-1:0] o;
        logic                       zero;
    } pass_t;

    typedef struct packed {
        logic                       hit;
        logic [TM_W-1:0]            tm;
        logic                       tneg;
        logic [2:0][UM_W-1:0]       um;
        logic [2:0]                 dn;
        logic [2:0][COORD_BITS-1:0] o;
    } tail_side_t;

endpackage

/* rtl/rsi_sqrt.sv */
// Pipelined floor square root, one result bit per stage, with sideband.
module rsi_sqrt #(
    parameter int IN_W   = 64,
    parameter int OUT_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [IN_W-1:0]   radicand,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [OUT_W-1:0]  root,
    output logic [SIDE_W-1:0] side_out
);

    localparam int RW = IN_W + 2;

    logic              valid_reg [OUT_W];
    logic [IN_W-1:0]   rem_reg   [OUT_W];
    logic [OUT_W-1:0]  root_reg  [OUT_W];
    logic [SIDE_W-1:0] side_reg  [OUT_W];

    for (genvar j = 0; j < OUT_W; j++) begin : g_stage
        localparam int B = OUT_W - 1 - j;

        logic              v_in;
        logic [IN_W-1:0]   rem_in;
        logic [IN_W-1:0]   rem_next;
        logic [OUT_W-1:0]  root_in;
        logic [OUT_W-1:0]  root_next;
        logic [SIDE_W-1:0] s_in;
        logic [RW-1:0]     trial;

        if (j == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = radicand;
            assign root_in = '0;
            assign s_in    = side_in;
        end
        else begin : g_rest
            assign v_in    = valid_reg[j-1];
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign s_in    = side_reg[j-1];
        end

        // remainder holds radicand - root^2; trial is (2*root + 2^B) * 2^B
        always_comb
        begin
            trial = (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));
            if (RW'(rem_in) >= trial)
            begin
                rem_next  = rem_in - trial[IN_W-1:0];
                root_next = root_in | (OUT_W'(1) << B);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (adv)
                valid_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                side_reg[j] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[OUT_W-1];
    assign root      = root_reg[OUT_W-1];
    assign side_out  = side_reg[OUT_W-1];

endmodule

/* rtl/rsi_div.sv */
// Three-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
module rsi_div #(
    parameter int NUM_W  = 61,
    parameter int DEN_W  = 32,
    parameter int Q_W    = 31,
    parameter int SIDE_W = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [2:0][NUM_W-1:0] num,
    input  logic [DEN_W-1:0]      den,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  out_valid,
    output logic [2:0][Q_W-1:0]   quot,
    output logic [SIDE_W-1:0]     side_out
);

    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic                  valid_reg [Q_W];
    logic [2:0][NUM_W-1:0] rem_reg   [Q_W];
    logic [2:0][Q_W-1:0]   q_reg     [Q_W];
    logic [DEN_W-1:0]      den_reg   [Q_W];
    logic [SIDE_W-1:0]     side_reg  [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        localparam int B = Q_W - 1 - j;

        logic                  v_in;
        logic [2:0][NUM_W-1:0] rem_in;
        logic [2:0][NUM_W-1:0] rem_next;
        logic [2:0][Q_W-1:0]   q_in;
        logic [2:0][Q_W-1:0]   q_next;
        logic [DEN_W-1:0]      d_in;
        logic [SIDE_W-1:0]     s_in;
        logic [CW-1:0]         sub;

        if (j == 0) begin : g_first
            assign v_in   = in_valid;
            assign rem_in = num;
            assign q_in   = '0;
            assign d_in   = den;
            assign s_in   = side_in;
        end
        else begin : g_rest
            assign v_in   = valid_reg[j-1];
            assign rem_in = rem_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign d_in   = den_reg[j-1];
            assign s_in   = side_reg[j-1];
        end

        always_comb
        begin
            sub = CW'(d_in) << B;
            for (int l = 0; l < 3; l++)
            begin
                if (CW'(rem_in[l]) >= sub)
                begin
                    rem_next[l] = rem_in[l] - sub[NUM_W-1:0];
                    q_next[l]   = q_in[l] | (Q_W'(1) << B);
                end
                else
                begin
                    rem_next[l] = rem_in[l];
                    q_next[l]   = q_in[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (adv)
                valid_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[j]  <= rem_next;
                q_reg[j]    <= q_next;
                den_reg[j]  <= d_in;
                side_reg[j] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quot      = q_reg[Q_W-1];
    assign side_out  = side_reg[Q_W-1];

endmodule

/* rtl/rsi_front.sv */
// Front stages: center offset, direction magnitudes, normalizing shift, squared length.
module rsi_front
    import rsi_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  ray_t                       ray,
    input  logic [2:0][COORD_BITS-1:0] center,
    output logic                       out_valid,
    output logic [DSQ_W-1:0]           dsq,
    output front_side_t                side
);

    logic [2:0][COORD_BITS-1:0] o_vec;
    logic [2:0][COORD_BITS-1:0] d_vec;
    logic [2:0][AM_W-1:0]       a_ext;
    logic [2:0][AM_W-1:0]       am_next;
    logic [2:0]                 an_next;
    logic [2:0][COORD_BITS-1:0] dm_next;
    logic [2:0]                 dn_next;
    logic [COORD_BITS-1:0]      m_next;

    logic                       va_reg;
    logic [2:0][AM_W-1:0]       am_a_reg;
    logic [2:0]                 an_a_reg;
    logic [2:0][COORD_BITS-1:0] dm_a_reg;
    logic [2:0]                 dn_a_reg;
    logic [2:0][COORD_BITS-1:0] o_a_reg;
    logic [COORD_BITS-1:0]      m_a_reg;

    logic [LZ_W-1:0]            lz;
    logic [2:0][COORD_BITS-1:0] dm_sh;
    front_side_t                side_b_next;

    logic                       vb_reg;
    front_side_t                side_b_reg;
    logic                       vc_reg;
    logic [2:0][2*NM_W-1:0]     sq_c_reg;
    front_side_t                side_c_reg;
    logic                       vd_reg;
    logic [DSQ_W-1:0]           dsq_reg;
    front_side_t                side_d_reg;

    // stage A: a = center - origin, magnitudes and signs, largest direction magnitude
    always_comb
    begin
        o_vec  = {ray.origin_z, ray.origin_y, ray.origin_x};
        d_vec  = {ray.dir_z, ray.dir_y, ray.dir_x};
        m_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            a_ext[i]   = {center[i][COORD_BITS-1], center[i]}
                       - {o_vec[i][COORD_BITS-1], o_vec[i]};
            an_next[i] = a_ext[i][AM_W-1];
            am_next[i] = an_next[i] ? ('0 - a_ext[i]) : a_ext[i];
            dn_next[i] = d_vec[i][COORD_BITS-1];
            dm_next[i] = dn_next[i] ? ('0 - d_vec[i]) : d_vec[i];
            if (dm_next[i] > m_next)
                m_next = dm_next[i];
        end
    end

    // stage B: shift so the largest magnitude has its top bit at NM_W-1
    always_comb
    begin
        lz = LZ_W'(COORD_BITS);
        for (int i = 0; i < COORD_BITS; i++)
        begin
            if (m_a_reg[i])
                lz = LZ_W'(COORD_BITS - 1 - i);
        end
        side_b_next.am   = am_a_reg;
        side_b_next.an   = an_a_reg;
        side_b_next.dn   = dn_a_reg;
        side_b_next.o    = o_a_reg;
        side_b_next.zero = (m_a_reg == '0);
        for (int i = 0; i < 3; i++)
        begin
            dm_sh[i]           = dm_a_reg[i] << lz;
            side_b_next.dmn[i] = dm_sh[i][COORD_BITS-1:1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            am_a_reg   <= am_next;
            an_a_reg   <= an_next;
            dm_a_reg   <= dm_next;
            dn_a_reg   <= dn_next;
            o_a_reg    <= o_vec;
            m_a_reg    <= m_next;
            side_b_reg <= side_b_next;
            for (int i = 0; i < 3; i++)
                sq_c_reg[i] <= side_b_reg.dmn[i] * side_b_reg.dmn[i];
            side_c_reg <= side_b_reg;
            dsq_reg    <= DSQ_W'(sq_c_reg[0]) + DSQ_W'(sq_c_reg[1]) + DSQ_W'(sq_c_reg[2]);
            side_d_reg <= side_c_reg;
        end
    end

    assign out_valid = vd_reg;
    assign dsq       = dsq_reg;
    assign side      = side_d_reg;

endmodule

/* rtl/rsi_dot.sv */
// Middle stages: t = a.u, |a|^2, perpendicular distance test, radicand for the chord.
module rsi_dot
    import rsi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic [2:0][UM_W-1:0] um,
    input  dot_side_t            side,
    input  logic [R_W-1:0]       radius,
    output logic                 out_valid,
    output logic [R2_W-1:0]      radicand,
    output tail_side_t           side_out
);

    localparam int TR_W = SUM_W + 1;
    localparam logic [TR_W-1:0] HALF = TR_W'(1) << (UNIT_BITS - 1);

    logic                   v1_reg;
    logic [2:0][PROD_W-1:0] prod_reg;
    logic [2:0][SQ_W-1:0]   sq_reg;
    logic [2:0]             same_reg;
    pass_t                  pass1_reg;

    logic [SUM_W-1:0]       pos_next;
    logic [SUM_W-1:0]       neg_next;
    logic [ASQ_W-1:0]       asq_next;
    logic                   v2_reg;
    logic [SUM_W-1:0]       pos_reg;
    logic [SUM_W-1:0]       neg_reg;
    logic [ASQ_W-1:0]       asq2_reg;
    pass_t                  pass2_reg;

    logic                   tneg_next;
    logic [SUM_W-1:0]       t_abs;
    logic [TR_W-1:0]        t_rnd;
    logic                   v3_reg;
    logic [TM_W-1:0]        tm3_reg;
    logic                   tneg3_reg;
    logic [ASQ_W-1:0]       asq3_reg;
    pass_t                  pass3_reg;

    logic                   v4_reg;
    logic [ASQ_W-1:0]       t2_reg;
    logic [R2_W-1:0]        r2_reg;
    logic [TM_W-1:0]        tm4_reg;
    logic                   tneg4_reg;
    logic [ASQ_W-1:0]       asq4_reg;
    pass_t                  pass4_reg;

    logic [ASQ_W-1:0]       perp2;
    logic                   hit_next;
    logic [ASQ_W-1:0]       chord;
    logic                   v5_reg;
    logic [R2_W-1:0]        rad_reg;
    tail_side_t             side5_next;
    tail_side_t             side5_reg;

    // terms whose signs agree add to t, the others subtract
    always_comb
    begin
        pos_next = '0;
        neg_next = '0;
        asq_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            asq_next = asq_next + ASQ_W'(sq_reg[i]);
            if (same_reg[i])
                pos_next = pos_next + SUM_W'(prod_reg[i]);
            else
                neg_next = neg_next + SUM_W'(prod_reg[i]);
        end
    end

    // round half away from zero on the magnitude
    always_comb
    begin
        tneg_next = (neg_reg > pos_reg);
        t_abs     = tneg_next ? (neg_reg - pos_reg) : (pos_reg - neg_reg);
        t_rnd     = TR_W'(t_abs) + HALF;
    end

    always_comb
    begin
        perp2 = (t2_reg <= asq4_reg) ? (asq4_reg - t2_reg) : '0;
        hit_next = !pass4_reg.zero && (perp2 <= ASQ_W'(r2_reg));
        chord = ASQ_W'(r2_reg) - perp2;
        side5_next.hit  = hit_next;
        side5_next.tm   = tm4_reg;
        side5_next.tneg = tneg4_reg;
        side5_next.um   = pass4_reg.um;
        side5_next.dn   = pass4_reg.dn;
        side5_next.o    = pass4_reg.o;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= side.am[i] * um[i];
                sq_reg[i]   <= side.am[i] * side.am[i];
                same_reg[i] <= (side.an[i] == side.dn[i]);
            end
            pass1_reg.um   <= um;
            pass1_reg.dn   <= side.dn;
            pass1_reg.o    <= side.o;
            pass1_reg.zero <= side.zero;

            pos_reg   <= pos_next;
            neg_reg   <= neg_next;
            asq2_reg  <= asq_next;
            pass2_reg <= pass1_reg;

            tm3_reg   <= TM_W'(t_rnd >> UNIT_BITS);
            tneg3_reg <= tneg_next;
            asq3_reg  <= asq2_reg;
            pass3_reg <= pass2_reg;

            t2_reg    <= tm3_reg * tm3_reg;
            r2_reg    <= radius * radius;
            tm4_reg   <= tm3_reg;
            tneg4_reg <= tneg3_reg;
            asq4_reg  <= asq3_reg;
            pass4_reg <= pass3_reg;

            rad_reg   <= hit_next ? chord[R2_W-1:0] : '0;
            side5_reg <= side5_next;
        end
    end

    assign out_valid = v5_reg;
    assign radicand  = rad_reg;
    assign side_out  = side5_reg;

endmodule

/* rtl/rsi_tail.sv */
// Tail stages: signed distance along the ray, offsets, saturated hit point, output register.
module rsi_tail
    import rsi_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  logic           in_valid,
    input  logic [R_W-1:0] s,
    input  tail_side_t     side,
    output logic           out_valid,
    output hit_t           result
);

    localparam int K_W  = TM_W + 2;
    localparam int KR_W = KP_W + 1;
    localparam logic [KR_W-1:0] HALF = KR_W'(1) << (UNIT_BITS - 1);

    logic [K_W-1:0]         t_s;
    logic [K_W-1:0]         k;
    logic                   v1_reg;
    logic [KM_W-1:0]        km_reg;
    logic                   kneg1_reg;
    tail_side_t             side1_reg;

    logic                   v2_reg;
    logic [2:0][KP_W-1:0]   kp_reg;
    logic                   kneg2_reg;
    tail_side_t             side2_reg;

    logic [2:0][DL_W-1:0]   dl;
    logic [2:0][P_W-1:0]    p;
    logic [2:0][COORD_BITS-1:0] pt;
    hit_t                   result_next;
    logic                   v3_reg;
    hit_t                   result_reg;

    // k = t - s
    always_comb
    begin
        t_s = side.tneg ? ('0 - K_W'(side.tm)) : K_W'(side.tm);
        k   = t_s - K_W'(s);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dl[i] = DL_W'((KR_W'(kp_reg[i]) + HALF) >> UNIT_BITS);
            if (kneg2_reg != side2_reg.dn[i])
                p[i] = {{(P_W-COORD_BITS){side2_reg.o[i][COORD_BITS-1]}}, side2_reg.o[i]}
                     - P_W'(dl[i]);
            else
                p[i] = {{(P_W-COORD_BITS){side2_reg.o[i][COORD_BITS-1]}}, side2_reg.o[i]}
                     + P_W'(dl[i]);
            // clamp to the signed coordinate range
            if (!p[i][P_W-1] && (p[i][P_W-2:COORD_BITS-1] != '0))
                pt[i] = {1'b0, {(COORD_BITS-1){1'b1}}};
            else if (p[i][P_W-1] && !(&p[i][P_W-2:COORD_BITS-1]))
                pt[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
            else
                pt[i] = p[i][COORD_BITS-1:0];
            if (!side2_reg.hit)
                pt[i] = '0;
        end
        result_next.hit     = side2_reg.hit;
        result_next.point_x = pt[0];
        result_next.point_y = pt[1];
        result_next.point_z = pt[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            km_reg    <= k[K_W-1] ? KM_W'('0 - k) : KM_W'(k);
            kneg1_reg <= k[K_W-1];
            side1_reg <= side;

            for (int i = 0; i < 3; i++)
                kp_reg[i] <= km_reg * side1_reg.um[i];
            kneg2_reg <= kneg1_reg;
            side2_reg <= side1_reg;

            result_reg <= result_next;
        end
    end

    assign out_valid = v3_reg;
    assign result    = result_reg;

endmodule

/* rtl/ray_sphere_intersect_top.sv */
// Ray/sphere intersection top level: configuration registers and the full pipeline.
//
// Channels: rays come in on ray_valid/ray_stall with payload ray (origin and
// unnormalized direction, signed Q16.16); results leave on hit_valid/hit_stall
// with payload result (hit flag and near hit point, zero on a miss).
// An item moves at a clock edge where valid is high and stall is low.
// The configuration port (cfg_we, cfg_index, cfg_data) sets center x/y/z and
// the radius; write it only while no ray is in flight.
// The pipeline has 4 front stages, 32 stages of the length square root,
// 31 stages of the direction divider, 5 dot/test stages, 31 stages of the
// chord square root and 3 tail stages ending in the output register.
// Throughput is one ray per cycle unless the output is stalled; every bit-serial
// unit is fully unrolled into stages, so no unit is shared between items.
// Reset clears all valid bits, the center to 0 and the radius to 1.0.
// While the output item is stalled the whole pipeline holds, and ray_stall
// is raised; nothing is dropped or duplicated.
`include "assert_macros.svh"

module ray_sphere_intersect_top
    import rsi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  ray_valid,
    output logic                  ray_stall,
    input  ray_t                  ray,
    output logic                  hit_valid,
    input  logic                  hit_stall,
    output hit_t                  result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0] cfg_data
);

    logic [2:0][COORD_BITS-1:0] center_reg;
    logic [R_W-1:0]             radius_reg;
    logic                       adv;

    logic                       front_valid;
    logic [DSQ_W-1:0]           front_dsq;
    front_side_t                front_side;

    logic                       len_valid;
    logic [LEN_W-1:0]           len;
    front_side_t                len_side;

    logic [2:0][NUM_W-1:0]      div_num;
    dot_side_t                  div_side_in;
    logic                       div_valid;
    logic [2:0][UM_W-1:0]       um;
    dot_side_t                  div_side;

    logic                       dot_valid;
    logic [R2_W-1:0]            dot_radicand;
    tail_side_t                 dot_side;

    logic                       s_valid;
    logic [R_W-1:0]             s_root;
    tail_side_t                 s_side;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            radius_reg <= R_W'(1) << FRAC_BITS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTER_X: center_reg[0] <= cfg_data;
                REG_CENTER_Y: center_reg[1] <= cfg_data;
                REG_CENTER_Z: center_reg[2] <= cfg_data;
                REG_RADIUS:   radius_reg    <= cfg_data[R_W-1:0];
            endcase
        end
    end

    // one enable for every stage; the pipeline only holds when the output is blocked
    assign adv       = !hit_valid || !hit_stall;
    assign ray_stall = !adv;

    rsi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (ray_valid),
        .ray       (ray),
        .center    (center_reg),
        .out_valid (front_valid),
        .dsq       (front_dsq),
        .side      (front_side)
    );

    rsi_sqrt #(
        .IN_W   (DSQ_W),
        .OUT_W  (LEN_W),
        .SIDE_W ($bits(front_side_t))
    ) u_len_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_valid),
        .radicand  (front_dsq),
        .side_in   (front_side),
        .out_valid (len_valid),
        .root      (len),
        .side_out  (len_side)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            div_num[i] = {len_side.dmn[i], UNIT_BITS'(0)};
        div_side_in.am   = len_side.am;
        div_side_in.an   = len_side.an;
        div_side_in.dn   = len_side.dn;
        div_side_in.o    = len_side.o;
        div_side_in.zero = len_side.zero;
    end

    rsi_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (LEN_W),
        .Q_W    (UM_W),
        .SIDE_W ($bits(dot_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (len_valid),
        .num       (div_num),
        .den       (len),
        .side_in   (div_side_in),
        .out_valid (div_valid),
        .quot      (um),
        .side_out  (div_side)
    );

    rsi_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (div_valid),
        .um        (um),
        .side      (div_side),
        .radius    (radius_reg),
        .out_valid (dot_valid),
        .radicand  (dot_radicand),
        .side_out  (dot_side)
    );

    rsi_sqrt #(
        .IN_W   (R2_W),
        .OUT_W  (R_W),
        .SIDE_W ($bits(tail_side_t))
    ) u_chord_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (dot_valid),
        .radicand  (dot_radicand),
        .side_in   (dot_side),
        .out_valid (s_valid),
        .root      (s_root),
        .side_out  (s_side)
    );

    rsi_tail u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_valid),
        .s         (s_root),
        .side      (s_side),
        .out_valid (hit_valid),
        .result    (result)
    );

    `ASSERT_IMP(a_miss_zero, hit_valid && !result.hit, result.point_x == '0 && result.point_y == '0 && result.point_z == '0)
    `ASSERT_NXT(a_hold_len, ray_stall, $stable(len_valid))
    `ASSERT_IMP(a_miss_no_chord, dot_valid && !dot_side.hit, dot_radicand == '0)

endmodule
